// ----- rtl/core/mtxa_pkg.sv -----
// ----------------------------------------------------------------------------
// mtxa_pkg
// Shared types and constants of the multistream threshold and
// cross-correlation aligner.
// ----------------------------------------------------------------------------
`default_nettype none

package mtxa_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int WORD_W    = 13;
    localparam int CORR_W    = 40;
    localparam int WIN_W     = 12;
    localparam int FRAME_W   = 13;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 64;
    localparam int OP_W      = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [WORD_W-1:0]          word_t;

    // Item operations.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALIGN = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Register indexes (byte address is 8 times the index).
    localparam logic [1:0] REG_AMP   = 2'd0;
    localparam logic [1:0] REG_CORR  = 2'd1;
    localparam logic [1:0] REG_WIN   = 2'd2;
    localparam logic [1:0] REG_FRAME = 2'd3;

    localparam logic [SAMPLE_W-1:0] AMP_RESET   = 16'd1000;
    localparam logic [CORR_W-1:0]   CORR_RESET  = 40'd200000;
    localparam logic [WIN_W-1:0]    WIN_RESET   = 12'd200;
    localparam logic [FRAME_W-1:0]  FRAME_RESET = 13'd320;

endpackage

`default_nettype wire

// ----- rtl/core/multistream_threshold_xcorr_aligner_core.sv -----
// ----------------------------------------------------------------------------
// multistream_threshold_xcorr_aligner_core
// Per-slot sample buffers in one two-read-port memory, threshold search,
// cross-correlation check and frame-rounded shift computation.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid, in_ready, operation..count      | beat into block
//  out     | out_valid, out_ready, found..last         | beat out of block
//  cfg     | psel, penable, pwrite, paddr, pwdata, ... | APB register access
//
// Load, clear and ignored items are handled in the idle state; an item is
// taken only in the idle state, and a waiting result does not hold up loads.
// An align item scans each sample in a read and a check state, correlates each
// sample pair in read, multiply and accumulate states, and uses one pass of the
// shared bit-serial divider per normalization and per contributor shift.
// Reset clears counts, alignment words and registers; buffer contents are
// left undefined and are never used past a slot's count.
`default_nettype none

module multistream_threshold_xcorr_aligner_core #(
    parameter int GROUPS         = 2,
    parameter int CONTRIBUTORS   = 4,
    parameter int BUFFER_SAMPLES = 2048
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           operation,
    input  wire logic                                 group,
    input  wire logic [1:0]                           contributor,
    input  wire logic signed [15:0]                   sample,
    input  wire logic [2:0]                           contributor_count,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      found,
    output logic [1:0]                                result_contributor,
    output logic [12:0]                               offset_bytes,
    output logic [12:0]                               shift_intervals,
    output logic                                      last,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mtxa_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [mtxa_pkg::PDATA_W-1:0]         pwdata,
    output logic [mtxa_pkg::PDATA_W-1:0]              prdata,
    output logic                                      pready
);

    localparam int SLOTS  = GROUPS * CONTRIBUTORS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH  = SLOTS * BUFFER_SAMPLES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(BUFFER_SAMPLES);
    localparam int CNT_W  = $clog2(BUFFER_SAMPLES + 1);
    localparam int IX_W   = ((IDX_W > 13) ? IDX_W : 13) + 1;
    localparam int CI_W   = $clog2(CONTRIBUTORS + 1);
    localparam int SUM_W  = 32 + mtxa_pkg::WIN_W + $clog2(CONTRIBUTORS) + 1;
    localparam int DVS_W  = 18;
    localparam int DC_W   = $clog2(SUM_W + 1);
    localparam int WW     = mtxa_pkg::WORD_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_NF       = 4'd1;
    localparam logic [3:0] S_SCAN_SEL = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CHK = 4'd4;
    localparam logic [3:0] S_REF      = 4'd5;
    localparam logic [3:0] S_CORR_RD  = 4'd6;
    localparam logic [3:0] S_CORR_MUL = 4'd7;
    localparam logic [3:0] S_CORR_ACC = 4'd8;
    localparam logic [3:0] S_NORM     = 4'd9;
    localparam logic [3:0] S_DIV      = 4'd10;
    localparam logic [3:0] S_JUDGE    = 4'd11;
    localparam logic [3:0] S_FAIL     = 4'd12;
    localparam logic [3:0] S_SH_SEL   = 4'd13;
    localparam logic [3:0] S_EMIT     = 4'd14;

    // Configuration registers.
    logic signed [15:0]              amp_reg;
    logic [mtxa_pkg::CORR_W-1:0]     corr_reg;
    logic [mtxa_pkg::WIN_W-1:0]      win_raw_reg;
    logic [mtxa_pkg::FRAME_W-1:0]    frame_raw_reg;

    // Sample memory and per-slot state.
    mtxa_pkg::sample_t               mem [DEPTH];
    mtxa_pkg::sample_t               rd_a_reg;
    mtxa_pkg::sample_t               rd_b_reg;
    logic [ADDR_W-1:0]               rd_addr_a;
    logic [ADDR_W-1:0]               rd_addr_b;
    logic                            wr_en;
    logic [ADDR_W-1:0]               wr_addr;
    logic [CNT_W-1:0]                wc_reg   [SLOTS];
    mtxa_pkg::word_t                 word_reg [SLOTS];

    // Sequencer state.
    logic [3:0]                      state_reg;
    logic                            g_reg;
    logic [CI_W-1:0]                 cnt_reg;
    logic [CI_W-1:0]                 j_reg;
    logic [CI_W-1:0]                 ref_reg;
    logic [IX_W-1:0]                 s_reg;
    logic [IX_W-1:0]                 n_reg;
    logic                            miss_reg;
    logic [5:0]                      cm1sq_reg;
    logic [WW:0]                     refoff_reg;
    mtxa_pkg::word_t                 refword_reg;
    logic [IX_W-1:0]                 xs_reg;
    logic                            fy_reg;
    logic                            fx_reg;
    logic signed [31:0]              prod_reg;
    logic signed [SUM_W-1:0]         sum_reg;
    logic                            neg_reg;
    logic [SUM_W-1:0]                q_reg;
    logic [DVS_W:0]                  rem_reg;
    logic [DVS_W-1:0]                dvs_reg;
    logic [DC_W-1:0]                 dcnt_reg;
    logic                            ph_shift_reg;
    logic [WW:0]                     off_reg;

    // Output register.
    logic                            out_valid_reg;
    logic                            found_reg;
    logic [1:0]                      rc_reg;
    logic [12:0]                     offb_reg;
    logic [12:0]                     shift_reg;
    logic                            last_reg;

    // Combinational helpers.
    logic [mtxa_pkg::WIN_W-1:0]      win;
    logic [10:0]                     half;
    logic [mtxa_pkg::FRAME_W-1:0]    fb;
    logic                            in_acc;
    logic                            out_free;
    logic [SLOT_W-1:0]               in_slot;
    logic                            in_slot_ok;
    logic [SLOT_W-1:0]               cur_slot;
    logic [SLOT_W-1:0]               ref_slot;
    logic [CI_W-1:0]                 cnt_in;
    mtxa_pkg::word_t                 cur_word;
    logic [IX_W-1:0]                 cur_wc;
    logic [IX_W-1:0]                 ref_wc;
    logic [IX_W-1:0]                 ys;
    logic [IX_W-1:0]                 idx_y;
    logic [IX_W-1:0]                 idx_x;
    logic [IX_W-1:0]                 s_next;
    logic                            exhausted;
    logic [DVS_W:0]                  trial;
    logic [DVS_W:0]                  rem_sh;
    logic                            pass;
    logic                            cfg_wr;

    assign win  = (win_raw_reg < 12'd2) ? 12'd2 : win_raw_reg;
    assign half = win[11:1];
    assign fb   = (frame_raw_reg < 13'd2) ? 13'd2 : frame_raw_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign in_slot    = SLOT_W'(32'(group) * CONTRIBUTORS + 32'(contributor));
    assign in_slot_ok = (32'(group) < GROUPS) && (32'(contributor) < CONTRIBUTORS);
    assign cnt_in     = (32'(contributor_count) > CONTRIBUTORS) ?
                        CI_W'(CONTRIBUTORS) : CI_W'(contributor_count);

    assign cur_slot = SLOT_W'(32'(g_reg) * CONTRIBUTORS + 32'(j_reg));
    assign ref_slot = SLOT_W'(32'(g_reg) * CONTRIBUTORS + 32'(ref_reg));
    assign cur_word = word_reg[cur_slot];
    assign cur_wc   = IX_W'(wc_reg[cur_slot]);
    assign ref_wc   = IX_W'(wc_reg[ref_slot]);

    assign ys    = (cur_word > WW'(half)) ? IX_W'(cur_word - WW'(half)) : '0;
    assign idx_y = ys + n_reg;
    assign idx_x = xs_reg + n_reg;

    assign s_next = s_reg + IX_W'(half);
    always_comb
    begin
        exhausted = 1'b0;
        for (int k = 0; k < CONTRIBUTORS; k++)
        begin
            if (CI_W'(k) < cnt_reg &&
                s_next >= IX_W'(wc_reg[SLOT_W'(32'(g_reg) * CONTRIBUTORS + k)]))
            begin
                exhausted = 1'b1;
            end
        end
    end

    // One restoring division step per cycle.
    assign rem_sh = {rem_reg[DVS_W-1:0], q_reg[SUM_W-1]};
    assign trial  = rem_sh - {1'b0, dvs_reg};

    // A negative quotient or a zero one never reaches a threshold above zero.
    assign pass = !(neg_reg && q_reg != '0) &&
                  (q_reg >= SUM_W'(corr_reg));

    // Memory addressing: port A serves the scan and the contributor side of
    // the correlation, port B the reference side.
    always_comb
    begin
        wr_en   = in_acc && operation == mtxa_pkg::OP_LOAD && in_slot_ok &&
                  32'(wc_reg[in_slot]) < BUFFER_SAMPLES;
        wr_addr = ADDR_W'(32'(in_slot) * BUFFER_SAMPLES + 32'(wc_reg[in_slot]));
        if (state_reg == S_SCAN_RD)
        begin
            rd_addr_a = ADDR_W'(32'(cur_slot) * BUFFER_SAMPLES + 32'(n_reg));
        end
        else
        begin
            rd_addr_a = ADDR_W'(32'(cur_slot) * BUFFER_SAMPLES + 32'(idx_y));
        end
        rd_addr_b = ADDR_W'(32'(ref_slot) * BUFFER_SAMPLES + 32'(idx_x));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= sample;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[4:3])
            mtxa_pkg::REG_AMP:   prdata = 64'({amp_reg});
            mtxa_pkg::REG_CORR:  prdata = 64'(corr_reg);
            mtxa_pkg::REG_WIN:   prdata = 64'(win_raw_reg);
            mtxa_pkg::REG_FRAME: prdata = 64'(frame_raw_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg       <= mtxa_pkg::AMP_RESET;
            corr_reg      <= mtxa_pkg::CORR_RESET;
            win_raw_reg   <= mtxa_pkg::WIN_RESET;
            frame_raw_reg <= mtxa_pkg::FRAME_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                mtxa_pkg::REG_AMP:   amp_reg       <= pwdata[15:0];
                mtxa_pkg::REG_CORR:  corr_reg      <= pwdata[39:0];
                mtxa_pkg::REG_WIN:   win_raw_reg   <= pwdata[11:0];
                mtxa_pkg::REG_FRAME: frame_raw_reg <= pwdata[12:0];
                default:             ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_CORR_RD:
            begin
                fy_reg <= idx_y < cur_wc;
                fx_reg <= idx_x < ref_wc;
            end
            S_CORR_MUL:
                prod_reg <= (fy_reg ? 32'(rd_a_reg) : 32'sd0) *
                            (fx_reg ? 32'(rd_b_reg) : 32'sd0);
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int k = 0; k < SLOTS; k++)
            begin
                wc_reg[k]   <= '0;
                word_reg[k] <= '0;
            end
            g_reg         <= 1'b0;
            cnt_reg       <= '0;
            j_reg         <= '0;
            ref_reg       <= '0;
            s_reg         <= '0;
            n_reg         <= '0;
            miss_reg      <= 1'b0;
            cm1sq_reg     <= '0;
            refoff_reg    <= '0;
            refword_reg   <= '0;
            xs_reg        <= '0;
            sum_reg       <= '0;
            neg_reg       <= 1'b0;
            q_reg         <= '0;
            rem_reg       <= '0;
            dvs_reg       <= '0;
            dcnt_reg      <= '0;
            ph_shift_reg  <= 1'b0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            rc_reg        <= '0;
            offb_reg      <= '0;
            shift_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        case (operation)
                            mtxa_pkg::OP_LOAD:
                                if (wr_en)
                                begin
                                    wc_reg[in_slot] <= wc_reg[in_slot] + 1'b1;
                                end
                            mtxa_pkg::OP_CLEAR:
                                if (in_slot_ok)
                                begin
                                    wc_reg[in_slot]   <= '0;
                                    word_reg[in_slot] <= '0;
                                end
                            mtxa_pkg::OP_ALIGN:
                                if (32'(group) >= GROUPS || cnt_in < CI_W'(2))
                                begin
                                    state_reg <= S_NF;
                                end
                                else
                                begin
                                    g_reg     <= group;
                                    cnt_reg   <= cnt_in;
                                    cm1sq_reg <= 6'(32'(cnt_in - 1'b1) *
                                                    32'(cnt_in - 1'b1));
                                    s_reg     <= '0;
                                    j_reg     <= '0;
                                    miss_reg  <= 1'b0;
                                    state_reg <= S_SCAN_SEL;
                                end
                            default: ;
                        endcase
                    end
                end

                S_NF:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= 1'b0;
                        rc_reg        <= '0;
                        offb_reg      <= '0;
                        shift_reg     <= '0;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                S_SCAN_SEL:
                begin
                    if (j_reg == cnt_reg)
                    begin
                        j_reg      <= '0;
                        ref_reg    <= '0;
                        refoff_reg <= '0;
                        state_reg  <= miss_reg ? S_NF : S_REF;
                    end
                    else if (cur_word != '0)
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        n_reg     <= s_reg;
                        state_reg <= S_SCAN_RD;
                    end
                end

                S_SCAN_RD:
                begin
                    if (n_reg >= cur_wc)
                    begin
                        // No candidate: keep going so the others are found.
                        miss_reg  <= 1'b1;
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_SCAN_SEL;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end

                S_SCAN_CHK:
                begin
                    if (rd_a_reg > amp_reg)
                    begin
                        word_reg[cur_slot] <= (n_reg == '0) ? WW'(1) : n_reg[WW-1:0];
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_SCAN_SEL;
                    end
                    else
                    begin
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end

                S_REF:
                begin
                    if (j_reg == cnt_reg)
                    begin
                        xs_reg    <= (refword_reg > WW'(half)) ?
                                     IX_W'(refword_reg - WW'(half)) : '0;
                        j_reg     <= '0;
                        n_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_CORR_RD;
                    end
                    else
                    begin
                        if ({cur_word, 1'b0} > refoff_reg)
                        begin
                            refoff_reg  <= {cur_word, 1'b0};
                            ref_reg     <= j_reg;
                            refword_reg <= cur_word;
                        end
                        j_reg <= j_reg + 1'b1;
                    end
                end

                S_CORR_RD:
                begin
                    if (j_reg == cnt_reg)
                    begin
                        state_reg <= S_NORM;
                    end
                    else if (j_reg == ref_reg)
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_CORR_MUL;
                    end
                end

                S_CORR_MUL:
                    state_reg <= S_CORR_ACC;

                S_CORR_ACC:
                begin
                    sum_reg <= sum_reg + SUM_W'(prod_reg);
                    if (n_reg == IX_W'(win - 1'b1))
                    begin
                        n_reg <= '0;
                        j_reg <= j_reg + 1'b1;
                    end
                    else
                    begin
                        n_reg <= n_reg + 1'b1;
                    end
                    state_reg <= S_CORR_RD;
                end

                S_NORM:
                begin
                    neg_reg      <= sum_reg[SUM_W-1];
                    q_reg        <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                    rem_reg      <= '0;
                    dvs_reg      <= DVS_W'(32'(win) * 32'(cm1sq_reg));
                    dcnt_reg     <= DC_W'(SUM_W);
                    ph_shift_reg <= 1'b0;
                    state_reg    <= S_DIV;
                end

                S_DIV:
                begin
                    if (!trial[DVS_W])
                    begin
                        rem_reg <= trial;
                        q_reg   <= {q_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[SUM_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == DC_W'(1))
                    begin
                        state_reg <= ph_shift_reg ? S_EMIT : S_JUDGE;
                    end
                end

                S_JUDGE:
                begin
                    j_reg     <= '0;
                    state_reg <= pass ? S_SH_SEL : S_FAIL;
                end

                S_FAIL:
                begin
                    for (int k = 0; k < CONTRIBUTORS; k++)
                    begin
                        if (CI_W'(k) < cnt_reg)
                        begin
                            word_reg[SLOT_W'(32'(g_reg) * CONTRIBUTORS + k)] <= '0;
                        end
                    end
                    s_reg     <= s_next;
                    j_reg     <= '0;
                    miss_reg  <= 1'b0;
                    state_reg <= exhausted ? S_NF : S_SCAN_SEL;
                end

                S_SH_SEL:
                begin
                    off_reg      <= {cur_word, 1'b0};
                    q_reg        <= SUM_W'(refoff_reg - {cur_word, 1'b0}) +
                                    SUM_W'(fb[12:1]);
                    rem_reg      <= '0;
                    dvs_reg      <= DVS_W'(fb);
                    dcnt_reg     <= DC_W'(SUM_W);
                    ph_shift_reg <= 1'b1;
                    state_reg    <= S_DIV;
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        word_reg[cur_slot] <= q_reg[WW-1:0];
                        out_valid_reg <= 1'b1;
                        found_reg     <= 1'b1;
                        rc_reg        <= j_reg[1:0];
                        offb_reg      <= off_reg[WW] ? 13'h1FFF : off_reg[WW-1:0];
                        shift_reg     <= q_reg[WW-1:0];
                        last_reg      <= (j_reg + 1'b1 == cnt_reg);
                        if (j_reg + 1'b1 == cnt_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_SH_SEL;
                        end
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign found              = found_reg;
    assign result_contributor = rc_reg;
    assign offset_bytes       = offb_reg;
    assign shift_intervals    = shift_reg;
    assign last               = last_reg;

`ifndef ASSERT_OFF
    // The slot addressed by the input never holds more samples than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wc_reg[in_slot]) <= BUFFER_SAMPLES)
        else $error("slot count exceeds buffer size");

    // A not-found beat is always a lone, zeroed, final result.
    a_nf_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last && result_contributor == 2'd0 &&
        offset_bytes == 13'd0 && shift_intervals == 13'd0)
        else $error("malformed not-found result");

    // When the divider finishes, its result goes to the judge or emit state.
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && dcnt_reg == DC_W'(1) |=>
        state_reg == S_EMIT || state_reg == S_JUDGE)
        else $error("divider finished in the wrong place");

    // A scan compare only follows a read that lay below the slot count.
    a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_CHK |-> $past(state_reg) == S_SCAN_RD &&
        $past(n_reg < cur_wc))
        else $error("scan read past written samples");
`endif

endmodule

`default_nettype wire
